FILE: hdl/ghbl_pkg.sv
// Shared constants, codes and types of the grid height bilinear lookup.
`timescale 1ns / 1ps
package ghbl_pkg;

  localparam int ROWS   = 1024;
  localparam int COLS   = 2048;
  localparam int ROW_W  = $clog2(ROWS);
  localparam int COL_W  = $clog2(COLS);
  localparam int ADDR_W = ROW_W + COL_W;
  localparam int DEPTH  = 1 << ADDR_W;
  localparam int HGT_W  = 16;

  // shared divider sizes
  localparam int DIV_W  = 48;
  localparam int DEN_W  = 28;
  localparam int STEP_W = 6;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_LAT  = 2'd1;
  localparam logic [1:0] ST_LON  = 2'd2;
  localparam logic [1:0] ST_EAST = 2'd3;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [2:0] REG_ORIGIN_LAT = 3'd0;
  localparam logic [2:0] REG_ORIGIN_LON = 3'd1;
  localparam logic [2:0] REG_STEP_LAT   = 3'd2;
  localparam logic [2:0] REG_STEP_LON   = 3'd3;
  localparam logic [2:0] REG_ROWS_USED  = 3'd4;
  localparam logic [2:0] REG_COLS_USED  = 3'd5;
  localparam logic [2:0] REG_NEGATE     = 3'd6;
  localparam logic [2:0] REG_WRAP_LON   = 3'd7;

  typedef struct packed {
    logic              start;
    logic [DIV_W-1:0]  num;    // dividend, aligned to the top bit
    logic [DEN_W-1:0]  den;
    logic [STEP_W-1:0] steps;  // quotient bits to produce
  } div_cmd_t;

endpackage

FILE: hdl/ghbl_ram.sv
// Generic single write port RAM with registered read.
`timescale 1ns / 1ps
module ghbl_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hdl/ghbl_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module ghbl_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  ghbl_pkg::div_cmd_t           cmd,
  output logic                         done,
  output logic [ghbl_pkg::DIV_W-1:0]   quo,
  output logic [ghbl_pkg::DEN_W-1:0]   rem
);

  logic                          busy_r;
  logic                          done_r;
  logic [ghbl_pkg::STEP_W-1:0]   cnt_r;
  logic [ghbl_pkg::DIV_W-1:0]    quo_r;
  logic [ghbl_pkg::DEN_W-1:0]    rem_r;
  logic [ghbl_pkg::DEN_W-1:0]    den_r;
  logic [ghbl_pkg::DEN_W:0]      shifted;
  logic                          fits;

  assign shifted = {rem_r, quo_r[ghbl_pkg::DIV_W-1]};
  assign fits    = shifted >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (cmd.start) begin
        busy_r <= 1'b1;
        cnt_r  <= cmd.steps;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == ghbl_pkg::STEP_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      quo_r <= cmd.num;
      rem_r <= '0;
      den_r <= cmd.den;
    end else if (busy_r) begin
      quo_r <= {quo_r[ghbl_pkg::DIV_W-2:0], fits};
      rem_r <= fits ? ghbl_pkg::DEN_W'(shifted - {1'b0, den_r})
                    : shifted[ghbl_pkg::DEN_W-1:0];
    end
  end

  assign done = done_r;
  assign quo  = quo_r;
  assign rem  = rem_r;

endmodule

FILE: hdl/grid_height_bilinear_lookup.sv
// Top level: height grid store with bilinear lookup of queried points.
//
// Input words arrive on in_tvalid/in_tready; in_tuser is the op (0 load,
// 1 query). A load writes one height into the grid store and posts a word
// with depth 0, status 0; the next item is taken only after it posts.
// A query locates the grid cell by floor division, reads the four corner
// heights from the store's one read port and interpolates with one shared
// multiplier and one shared bit-serial divider. The divider makes one
// quotient bit per cycle over four divisions (18, 20, 30 and 48 bits), or
// three on the top row (18, 20 and 32 bits); a query that falls off the
// grid posts early, skipping the remaining divisions.
// One item is in flight at a time: in_tready is high only while the
// sequencer is idle, and the next item can be taken as soon as the
// previous one posts.
// The result word waits in an output register until out_tready takes it;
// meanwhile the sequencer takes and works the next item and holds that
// item's result until the register is free.
// Reset (rst_n low, synchronous) returns the sequencer to idle and loads
// the register defaults; the grid store is not cleared, so every cell must
// be loaded before a query reads it.
// cfg_we writes register cfg_index with cfg_wdata; the user must write only while idle (not enforced).
`timescale 1ns / 1ps
module grid_height_bilinear_lookup (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [79:0] in_tdata,  // grid_row, grid_col, height, lat_mdeg, lon_mdeg, pad
  input  logic        in_tuser,  // op
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata, // depth, status, pad
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [19:0] cfg_wdata
);

  typedef enum logic [4:0] {
    S_IDLE, S_PREP, S_ROW_GO, S_ROW_WAIT, S_COL_WAIT,
    S_RD0, S_RD1, S_RD2, S_RD3,
    S_M1, S_M2, S_M3, S_M4, S_ZN_WAIT,
    S_M5, S_M6, S_M7, S_M8, S_M9, S_FIN_WAIT, S_OUT
  } state_t;

  state_t state_r;

  // configuration
  logic signed [17:0] olat_r;
  logic signed [19:0] olon_r;
  logic [13:0]        slat_r, slon_r;
  logic [10:0]        rows_r;
  logic [11:0]        cols_r;
  logic               neg_r, wrap_r;

  // query work registers
  logic signed [17:0] lat_r;
  logic signed [20:0] lon_r;
  logic signed [18:0] dlat_r;
  logic signed [20:0] dlon_r;
  logic [ghbl_pkg::ROW_W-1:0] row_r;
  logic [ghbl_pkg::COL_W-1:0] col_r;
  logic               top_r;
  logic [13:0]        fx_r, fy_r;
  logic signed [15:0] z00_r, z01_r, z10_r, z11_r;
  logic signed [48:0] mul_r, acc_r;
  logic signed [32:0] a_r;
  logic signed [17:0] zn_r;
  logic               dneg_r;

  logic               out_valid_r;
  logic signed [15:0] depth_r;
  logic [1:0]         status_r;
  logic signed [15:0] res_depth_r;
  logic [1:0]         res_status_r;

  // effective sizes
  logic [13:0] dx, dy;
  logic [10:0] rows_eff;
  logic [11:0] cols_eff;
  assign dx = (slon_r == '0) ? 14'd1 : slon_r;
  assign dy = (slat_r == '0) ? 14'd1 : slat_r;
  assign rows_eff = (rows_r > 11'(ghbl_pkg::ROWS)) ? 11'(ghbl_pkg::ROWS) : rows_r;
  assign cols_eff = (cols_r > 12'(ghbl_pkg::COLS)) ? 12'(ghbl_pkg::COLS) : cols_r;

  // input fields
  logic [9:0]         f_row;
  logic [10:0]        f_col;
  logic [15:0]        f_hgt;
  logic signed [17:0] f_lat;
  logic signed [19:0] f_lon;
  assign f_row = in_tdata[9:0];
  assign f_col = in_tdata[20:10];
  assign f_hgt = in_tdata[36:21];
  assign f_lat = in_tdata[54:37];
  assign f_lon = in_tdata[74:55];

  logic in_acc;
  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;

  // grid store
  logic                        ram_we;
  logic [ghbl_pkg::ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [15:0]                 ram_rdata;
  logic [ghbl_pkg::ROW_W-1:0]  row_up;
  logic [ghbl_pkg::COL_W-1:0]  col_east;

  assign ram_we    = in_acc && (in_tuser == ghbl_pkg::OP_LOAD)
                     && ({1'b0, f_row} < 11'(ghbl_pkg::ROWS))
                     && ({1'b0, f_col} < 12'(ghbl_pkg::COLS));
  assign ram_waddr = {ghbl_pkg::ROW_W'(f_row), ghbl_pkg::COL_W'(f_col)};
  assign row_up    = row_r + 1'b1;
  assign col_east  = col_r + 1'b1;

  always_comb begin
    case (state_r)
      S_RD1:   ram_raddr = {row_r, col_east};
      S_RD2:   ram_raddr = {row_up, col_r};
      S_RD3:   ram_raddr = {row_up, col_east};
      default: ram_raddr = {row_r, col_r};
    endcase
  end

  ghbl_ram #(
    .WIDTH(16),
    .DEPTH(ghbl_pkg::DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(f_hgt),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // shared multiplier
  logic signed [32:0] mul_a;
  logic signed [15:0] mul_b;
  logic signed [16:0] dz_s, dz_n;
  assign dz_s = 17'(z01_r) - 17'(z00_r);
  assign dz_n = 17'(z11_r) - 17'(z10_r);

  always_comb begin
    case (state_r)
      S_M1: begin
        mul_a = 33'(z00_r);
        mul_b = {2'b0, dx};
      end
      S_M2: begin
        mul_a = 33'(dz_s);
        mul_b = {2'b0, fx_r};
      end
      S_M3: begin
        mul_a = 33'(dz_n);
        mul_b = {2'b0, fx_r};
      end
      S_M5: begin
        mul_a = 33'(zn_r);
        mul_b = {2'b0, dx};
      end
      S_M6: begin
        mul_a = mul_r[32:0];
        mul_b = {2'b0, fy_r};
      end
      S_M7: begin
        mul_a = a_r;
        mul_b = {2'b0, 14'(dy - fy_r)};
      end
      S_M8: begin
        mul_a = {19'b0, dx};
        mul_b = {2'b0, dy};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    mul_r <= mul_a * mul_b;
  end

  // shared divider
  ghbl_pkg::div_cmd_t           div_cmd;
  logic                         div_done;
  logic [ghbl_pkg::DIV_W-1:0]   div_quo;
  logic [ghbl_pkg::DEN_W-1:0]   div_rem;
  logic [48:0]                  mag_p3, mag_a, mag_acc;

  assign mag_p3  = mul_r[48] ? 49'(-mul_r) : mul_r;
  assign mag_a   = a_r[32]   ? 49'(-a_r)   : 49'(a_r);
  assign mag_acc = acc_r[48] ? 49'(-acc_r) : acc_r;

  always_comb begin
    div_cmd = '0;
    case (state_r)
      S_ROW_GO: begin
        div_cmd.start = (dlat_r >= 0);
        div_cmd.num   = {dlat_r[17:0], 30'b0};
        div_cmd.den   = ghbl_pkg::DEN_W'(dy);
        div_cmd.steps = 6'd18;
      end
      S_ROW_WAIT: begin
        div_cmd.start = div_done && ({30'b0, div_quo[17:0]} < 48'(rows_eff))
                        && (dlon_r >= 0);
        div_cmd.num   = {dlon_r[19:0], 28'b0};
        div_cmd.den   = ghbl_pkg::DEN_W'(dx);
        div_cmd.steps = 6'd20;
      end
      S_M4: begin
        div_cmd.start = 1'b1;
        div_cmd.den   = ghbl_pkg::DEN_W'(dx);
        if (top_r) begin
          div_cmd.num   = {mag_a[31:0], 16'b0};
          div_cmd.steps = 6'd32;
        end else begin
          div_cmd.num   = {mag_p3[29:0], 18'b0};
          div_cmd.steps = 6'd30;
        end
      end
      S_M9: begin
        div_cmd.start = 1'b1;
        div_cmd.num   = mag_acc[47:0];
        div_cmd.den   = mul_r[27:0];
        div_cmd.steps = 6'd48;
      end
      default: div_cmd = '0;
    endcase
  end

  ghbl_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .cmd  (div_cmd),
    .done (div_done),
    .quo  (div_quo),
    .rem  (div_rem)
  );

  // signed results from the divider magnitude
  logic signed [16:0] q_s, z_fin, z_neg;
  assign q_s   = dneg_r ? 17'(-div_quo[16:0]) : 17'(div_quo[16:0]);
  assign z_neg = -q_s;
  assign z_fin = !neg_r ? q_s : (z_neg > 17'sd32767 ? 17'sd32767 : z_neg);

  logic signed [20:0] lon_wrapped;
  assign lon_wrapped = (wrap_r && f_lon < 0) ? 21'(f_lon) + 21'sd360000 : 21'(f_lon);

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      olat_r <= -18'sd90000;
      olon_r <= '0;
      slat_r <= 14'd100;
      slon_r <= 14'd100;
      rows_r <= 11'd1024;
      cols_r <= 12'd2048;
      neg_r  <= 1'b1;
      wrap_r <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        ghbl_pkg::REG_ORIGIN_LAT: olat_r <= cfg_wdata[17:0];
        ghbl_pkg::REG_ORIGIN_LON: olon_r <= cfg_wdata;
        ghbl_pkg::REG_STEP_LAT:   slat_r <= cfg_wdata[13:0];
        ghbl_pkg::REG_STEP_LON:   slon_r <= cfg_wdata[13:0];
        ghbl_pkg::REG_ROWS_USED:  rows_r <= cfg_wdata[10:0];
        ghbl_pkg::REG_COLS_USED:  cols_r <= cfg_wdata[11:0];
        ghbl_pkg::REG_NEGATE:     neg_r  <= cfg_wdata[0];
        ghbl_pkg::REG_WRAP_LON:   wrap_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      depth_r     <= '0;
      status_r    <= ghbl_pkg::ST_OK;
    end else begin
      // post a finished result once the output register is free
      if (state_r == S_OUT && (!out_valid_r || out_tready)) begin
        out_valid_r <= 1'b1;
        depth_r     <= res_depth_r;
        status_r    <= res_status_r;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            lat_r <= f_lat;
            lon_r <= lon_wrapped;
            if (in_tuser == ghbl_pkg::OP_LOAD) begin
              res_depth_r  <= '0;
              res_status_r <= ghbl_pkg::ST_OK;
              state_r      <= S_OUT;
            end else begin
              state_r <= S_PREP;
            end
          end
        end
        S_PREP: begin
          dlat_r  <= 19'(lat_r) - 19'(olat_r);
          dlon_r  <= lon_r - 21'(olon_r);
          state_r <= S_ROW_GO;
        end
        S_ROW_GO: begin
          if (dlat_r < 0) begin
            res_depth_r  <= '0;
            res_status_r <= ghbl_pkg::ST_LAT;
            state_r      <= S_OUT;
          end else begin
            state_r <= S_ROW_WAIT;
          end
        end
        S_ROW_WAIT: begin
          if (div_done) begin
            row_r <= div_quo[ghbl_pkg::ROW_W-1:0];
            top_r <= ({30'b0, div_quo[17:0]} + 48'd1) >= 48'(rows_eff);
            fy_r  <= div_rem[13:0];
            if ({30'b0, div_quo[17:0]} >= 48'(rows_eff)) begin
              res_depth_r  <= '0;
              res_status_r <= ghbl_pkg::ST_LAT;
              state_r      <= S_OUT;
            end else if (dlon_r < 0) begin
              res_depth_r  <= '0;
              res_status_r <= ghbl_pkg::ST_LON;
              state_r      <= S_OUT;
            end else begin
              state_r <= S_COL_WAIT;
            end
          end
        end
        S_COL_WAIT: begin
          if (div_done) begin
            col_r <= div_quo[ghbl_pkg::COL_W-1:0];
            fx_r  <= div_rem[13:0];
            if ({28'b0, div_quo[19:0]} >= 48'(cols_eff)) begin
              res_depth_r  <= '0;
              res_status_r <= ghbl_pkg::ST_LON;
              state_r      <= S_OUT;
            end else if ({28'b0, div_quo[19:0]} + 48'd1 >= 48'(cols_eff)) begin
              res_depth_r  <= '0;
              res_status_r <= ghbl_pkg::ST_EAST;
              state_r      <= S_OUT;
            end else begin
              state_r <= S_RD0;
            end
          end
        end
        S_RD0: state_r <= S_RD1;
        S_RD1: begin
          z00_r   <= ram_rdata;
          state_r <= S_RD2;
        end
        S_RD2: begin
          z01_r   <= ram_rdata;
          state_r <= S_RD3;
        end
        S_RD3: begin
          z10_r   <= ram_rdata;
          state_r <= S_M1;
        end
        S_M1: begin
          z11_r   <= ram_rdata;
          state_r <= S_M2;
        end
        S_M2: begin
          acc_r   <= mul_r;
          state_r <= S_M3;
        end
        S_M3: begin
          a_r     <= 33'(acc_r + mul_r);
          state_r <= S_M4;
        end
        S_M4: begin
          dneg_r  <= top_r ? a_r[32] : mul_r[48];
          state_r <= top_r ? S_FIN_WAIT : S_ZN_WAIT;
        end
        S_ZN_WAIT: begin
          if (div_done) begin
            zn_r    <= 18'(z10_r) + 18'(q_s);
            state_r <= S_M5;
          end
        end
        S_M5: state_r <= S_M6;
        S_M6: state_r <= S_M7;
        S_M7: begin
          acc_r   <= mul_r;
          state_r <= S_M8;
        end
        S_M8: begin
          acc_r   <= acc_r + mul_r;
          state_r <= S_M9;
        end
        S_M9: begin
          dneg_r  <= acc_r[48];
          state_r <= S_FIN_WAIT;
        end
        S_FIN_WAIT: begin
          if (div_done) begin
            res_depth_r  <= z_fin[15:0];
            res_status_r <= ghbl_pkg::ST_OK;
            state_r      <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid_r || out_tready) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'b0, status_r, depth_r};

  a_hold_while_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("result word changed while stalled");

  a_div_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_ROW_WAIT || state_r == S_COL_WAIT ||
                  state_r == S_ZN_WAIT || state_r == S_FIN_WAIT))
    else $error("divider finished outside a wait state");

  a_error_zero_depth: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && status_r != ghbl_pkg::ST_OK) |-> (depth_r == '0))
    else $error("error status with nonzero depth");

  a_result_follows_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_tuser == ghbl_pkg::OP_LOAD) |=> (state_r == S_OUT))
    else $error("load result missing");

endmodule

FILE: tb/sv/testbench.sv
// Self-checking testbench for the grid height bilinear lookup: loads, queries, config sweeps.
`timescale 1ns / 1ps
module testbench;

  typedef struct {
    logic        op;
    logic [79:0] data;
  } word_t;

  typedef struct {
    logic signed [15:0] depth;
    logic [1:0]         status;
  } lookup_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [79:0] in_tdata = '0;  // grid_row, grid_col, height, lat_mdeg, lon_mdeg, pad
  logic        in_tuser = 1'b0;  // op
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;  // depth, status, pad
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [19:0] cfg_wdata = '0;

  grid_height_bilinear_lookup dut (.*);

  always #2 clk = ~clk;

  // shadow registers
  logic signed [17:0] sh_olat = -18'sd90000;
  logic signed [19:0] sh_olon = '0;
  logic [13:0]        sh_slat = 14'd100;
  logic [13:0]        sh_slon = 14'd100;
  logic [10:0]        sh_rows = 11'd1024;
  logic [11:0]        sh_cols = 12'd2048;
  logic               sh_neg = 1'b1;
  logic               sh_wrap = 1'b1;

  shortint grid_heights[int];   // contents as accepted by the block
  bit      planned_cells[int];  // cells loaded by some word already queued

  word_t   pending_words[$];
  lookup_t expected_lookups[$];

  int send_idle = 31;
  int recv_idle = 85;
  int hold_total = 0;
  int hold_done = 0;
  int mismatches = 0;
  logic in_took = 1'b0;
  word_t nxt;

  int r_lo, r_hi, c_lo, c_hi;
  bit region_ok;

  function automatic longint floor_div(longint n, longint d);
    longint q;
    q = n / d;
    if ((n % d) != 0 && n < 0) q--;
    return q;
  endfunction

  function automatic int cell_key(longint r, longint c);
    return int'(r) * ghbl_pkg::COLS + int'(c);
  endfunction

  function automatic longint height_at(longint r, longint c);
    int k;
    k = cell_key(r, c);
    return grid_heights.exists(k) ? longint'(grid_heights[k]) : 0;
  endfunction

  function automatic longint eff_dx();
    return (sh_slon == 0) ? 1 : longint'(sh_slon);
  endfunction

  function automatic longint eff_dy();
    return (sh_slat == 0) ? 1 : longint'(sh_slat);
  endfunction

  function automatic longint eff_rows();
    return (sh_rows > ghbl_pkg::ROWS) ? ghbl_pkg::ROWS : longint'(sh_rows);
  endfunction

  function automatic longint eff_cols();
    return (sh_cols > ghbl_pkg::COLS) ? ghbl_pkg::COLS : longint'(sh_cols);
  endfunction

  // find cell, fractions and status of a query point
  function automatic void locate(input logic signed [17:0] lat,
                                 input logic signed [19:0] lon_in,
                                 output longint row, output longint col, output longint fx,
                                 output longint fy, output logic [1:0] st);
    longint lon, dlat, dlon;
    lon = lon_in;
    if (sh_wrap && lon < 0) lon += 360000;
    dlat = longint'(lat) - longint'(sh_olat);
    dlon = lon - longint'(sh_olon);
    row = floor_div(dlat, eff_dy());
    col = floor_div(dlon, eff_dx());
    fx = dlon - col * eff_dx();
    fy = dlat - row * eff_dy();
    if (row < 0 || row >= eff_rows()) st = ghbl_pkg::ST_LAT;
    else if (col < 0 || col >= eff_cols()) st = ghbl_pkg::ST_LON;
    else if (col + 1 >= eff_cols()) st = ghbl_pkg::ST_EAST;
    else st = ghbl_pkg::ST_OK;
  endfunction

  function automatic lookup_t interpolate(logic signed [17:0] lat, logic signed [19:0] lon);
    lookup_t res;
    longint row, col, fx, fy, dx, dy, z00, z01, z10, z11, a, zn, z;
    logic [1:0] st;
    locate(lat, lon, row, col, fx, fy, st);
    res.depth = '0;
    res.status = st;
    if (st != ghbl_pkg::ST_OK) return res;
    dx = eff_dx();
    dy = eff_dy();
    z00 = height_at(row, col);
    z01 = height_at(row, col + 1);
    a = z00 * dx + (z01 - z00) * fx;
    if (row + 1 >= eff_rows()) begin
      z = a / dx;
    end else begin
      z10 = height_at(row + 1, col);
      z11 = height_at(row + 1, col + 1);
      zn = z10 + ((z11 - z10) * fx) / dx;
      z = (a * (dy - fy) + zn * dx * fy) / (dx * dy);
    end
    if (sh_neg) begin
      z = -z;
      if (z > 32767) z = 32767;
    end
    res.depth = z[15:0];
    return res;
  endfunction

  // a query may go out only if every corner it uses was loaded earlier
  function automatic bit query_safe(logic signed [17:0] lat, logic signed [19:0] lon);
    longint row, col, fx, fy;
    logic [1:0] st;
    locate(lat, lon, row, col, fx, fy, st);
    if (st != ghbl_pkg::ST_OK) return 1'b1;
    if (!planned_cells.exists(cell_key(row, col))) return 1'b0;
    if (!planned_cells.exists(cell_key(row, col + 1))) return 1'b0;
    if (row + 1 < eff_rows()) begin
      if (!planned_cells.exists(cell_key(row + 1, col))) return 1'b0;
      if (!planned_cells.exists(cell_key(row + 1, col + 1))) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic logic [15:0] pick_height();
    case ($urandom_range(4))
      0: return 16'h8000;
      1: return 16'h7FFF;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic push_load(int r, int c, logic [15:0] h);
    word_t w;
    w.op = ghbl_pkg::OP_LOAD;
    w.data = {5'b0, 20'($urandom), 18'($urandom), h, 11'(c), 10'(r)};
    planned_cells[cell_key(r, c)] = 1'b1;
    pending_words.push_back(w);
  endtask

  task automatic push_query(logic signed [17:0] lat, logic signed [19:0] lon);
    word_t w;
    w.op = ghbl_pkg::OP_QUERY;
    w.data = {5'b0, lon, lat, 16'($urandom), 11'($urandom), 10'($urandom)};
    pending_words.push_back(w);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [19:0] v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    case (idx)
      ghbl_pkg::REG_ORIGIN_LAT: sh_olat = v[17:0];
      ghbl_pkg::REG_ORIGIN_LON: sh_olon = v;
      ghbl_pkg::REG_STEP_LAT:   sh_slat = v[13:0];
      ghbl_pkg::REG_STEP_LON:   sh_slon = v[13:0];
      ghbl_pkg::REG_ROWS_USED:  sh_rows = v[10:0];
      ghbl_pkg::REG_COLS_USED:  sh_cols = v[11:0];
      ghbl_pkg::REG_NEGATE:     sh_neg = v[0];
      default:                  sh_wrap = v[0];
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic write_all(int olat, int olon, int slat, int slon, int rows, int cols,
                           int neg, int wrap);
    write_reg(ghbl_pkg::REG_ORIGIN_LAT, 20'(olat));
    write_reg(ghbl_pkg::REG_ORIGIN_LON, 20'(olon));
    write_reg(ghbl_pkg::REG_STEP_LAT, 20'(slat));
    write_reg(ghbl_pkg::REG_STEP_LON, 20'(slon));
    write_reg(ghbl_pkg::REG_ROWS_USED, 20'(rows));
    write_reg(ghbl_pkg::REG_COLS_USED, 20'(cols));
    write_reg(ghbl_pkg::REG_NEGATE, 20'(neg));
    write_reg(ghbl_pkg::REG_WRAP_LON, 20'(wrap));
  endtask

  // pick a small patch of cells that queries can reach, and load it whole
  task automatic new_region();
    longint rmax, cmax, rr, cr;
    region_ok = 1'b0;
    if (sh_olat > 131071 || sh_olon > 524287) return;
    rr = (131071 - longint'(sh_olat)) / eff_dy();
    cr = (524287 - longint'(sh_olon)) / eff_dx();
    rmax = (eff_rows() - 1 < rr) ? eff_rows() - 1 : rr;
    cmax = (eff_cols() - 2 < cr) ? eff_cols() - 2 : cr;
    if (rmax < 0 || cmax < 0) return;
    case ($urandom_range(3))
      0: begin r_lo = 0; c_lo = 0; end
      1: begin r_lo = int'(rmax); c_lo = int'(cmax); end
      default: begin
        r_lo = $urandom_range(int'(rmax));
        c_lo = $urandom_range(int'(cmax));
      end
    endcase
    r_hi = r_lo + $urandom_range(1, 3);
    c_hi = c_lo + $urandom_range(1, 4);
    if (r_hi > ghbl_pkg::ROWS - 1) r_hi = ghbl_pkg::ROWS - 1;
    if (c_hi > ghbl_pkg::COLS - 1) c_hi = ghbl_pkg::COLS - 1;
    for (int r = r_lo; r <= r_hi; r++)
      for (int c = c_lo; c <= c_hi; c++) push_load(r, c, pick_height());
    region_ok = 1'b1;
  endtask

  task automatic noise_word();
    logic signed [17:0] lat;
    logic signed [19:0] lon;
    lat = 18'($urandom);
    lon = 20'($urandom);
    if ($urandom_range(1)) begin
      // keep near the grid so that edge checks get hit
      lat = 18'(longint'(sh_olat) + $urandom_range(0, 3) * eff_dy() * eff_rows() / 2 - 5);
      lon = 20'(longint'(sh_olon) + longint'($urandom_range(0, 3)) * eff_dx() * eff_cols() / 2
                - $urandom_range(1, 0) * eff_dx());
    end
    if (query_safe(lat, lon)) push_query(lat, lon);
    else push_load($urandom_range(ghbl_pkg::ROWS - 1), $urandom_range(ghbl_pkg::COLS - 1),
                   pick_height());
  endtask

  task automatic aimed_query();
    longint r, c, lat, lon;
    if (!region_ok) begin
      noise_word();
      return;
    end
    r = $urandom_range(r_hi, r_lo);
    c = $urandom_range(c_hi, c_lo);
    lat = longint'(sh_olat) + r * eff_dy() + $urandom_range(int'(eff_dy() - 1));
    lon = longint'(sh_olon) + c * eff_dx() + $urandom_range(int'(eff_dx() - 1));
    if (sh_wrap && lon >= 0 && $urandom_range(2) == 0) lon -= 360000;
    if (lat < -131072 || lat > 131071 || lon < -524288 || lon > 524287 ||
        !query_safe(18'(lat), 20'(lon))) begin
      noise_word();
      return;
    end
    push_query(18'(lat), 20'(lon));
  endtask

  task automatic fill_phase(int n);
    new_region();
    for (int i = 0; i < n; i++) begin
      if (i % 60 == 59) new_region();
      case ($urandom_range(9))
        0, 1: begin
          if (region_ok) push_load($urandom_range(r_hi, r_lo), $urandom_range(c_hi, c_lo),
                                   pick_height());
          else push_load($urandom_range(ghbl_pkg::ROWS - 1),
                         $urandom_range(ghbl_pkg::COLS - 1), pick_height());
        end
        2: push_load($urandom_range(ghbl_pkg::ROWS - 1), $urandom_range(ghbl_pkg::COLS - 1),
                     pick_height());
        3, 4: noise_word();
        default: aimed_query();
      endcase
    end
  endtask

  // wait until nothing is queued, offered or in flight
  task automatic drain();
    do begin
      repeat (150) @(posedge clk);
    end while (pending_words.size() != 0 || expected_lookups.size() != 0 || in_tvalid);
  endtask

  // driver: hold the word until taken, then advance or idle
  always @(negedge clk) begin
    if (!in_tvalid || in_took) begin
      if (pending_words.size() > 0 && $urandom_range(99) >= send_idle) begin
        nxt = pending_words.pop_front();
        in_tvalid <= 1'b1;
        in_tuser <= nxt.op;
        in_tdata <= nxt.data;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // acceptance: update the grid copy or predict the lookup
  always @(posedge clk) begin
    lookup_t res;
    in_took <= rst_n && in_tvalid && in_tready;
    if (rst_n && in_tvalid && in_tready) begin
      res.depth = '0;
      res.status = ghbl_pkg::ST_OK;
      if (in_tuser == ghbl_pkg::OP_LOAD)
        grid_heights[cell_key(in_tdata[9:0], in_tdata[20:10])] = shortint'(in_tdata[36:21]);
      else
        res = interpolate(in_tdata[54:37], in_tdata[74:55]);
      expected_lookups.push_back(res);
    end
  end

  // receiver: long hold-offs first, then random stalls
  always @(negedge clk) begin
    if (hold_done < hold_total) begin
      hold_done <= hold_done + 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle);
    end
  end

  always @(posedge clk) begin
    lookup_t exp_res;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_lookups.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word: depth %0d status %0d",
                                       $signed(out_tdata[15:0]), out_tdata[17:16]);
      end else begin
        exp_res = expected_lookups.pop_front();
        if (out_tdata[15:0] !== exp_res.depth || out_tdata[17:16] !== exp_res.status) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected depth %0d status %0d, got depth %0d status %0d",
                     exp_res.depth, exp_res.status, $signed(out_tdata[15:0]),
                     out_tdata[17:16]);
        end
      end
    end
  end

  initial begin
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset settings: corners, saturation, top row, each status
    push_load(0, 0, 16'h8000);
    push_load(0, 1, 16'h7FFF);
    push_load(1, 0, 16'h0000);
    push_load(1, 1, 16'hFFFF);
    push_query(-18'sd90000, 20'sd0);
    push_query(-18'sd89950, 20'sd50);
    push_query(-18'sd89901, 20'sd99);
    push_load(1023, 2046, 16'd1234);
    push_load(1023, 2047, 16'h8000);
    push_query(18'sd12350, 20'sd204650);
    push_query(-18'sd90001, 20'sd10);
    push_query(18'sd12400, 20'sd10);
    push_query(-18'sd90000, -20'sd1);
    push_query(-18'sd90000, 20'sd204799);
    push_query(-18'sd90000, -20'sd360000);
    push_query(18'sd131071, 20'sd524287);
    push_query(-18'sd131072, -20'sd524288);
    fill_phase(190);
    drain();

    write_all(0, -360000, 1, 1, 2, 2, 0, 0);
    fill_phase(160);
    drain();

    send_idle = 85;
    recv_idle = 31;
    write_all(-90000, -360000, 10000, 10000, 2047, 4095, 1, 1);
    fill_phase(160);
    drain();

    // zero steps count as one; zero rows puts everything off grid
    write_all(90000, 360000, 0, 0, 0, 1, 0, 1);
    fill_phase(80);
    drain();

    send_idle = 0;
    recv_idle = 0;
    write_all(-1234, -5678, 37, 53, 1000, 2000, 1, 1);
    fill_phase(160);
    hold_total = hold_total + 400;
    drain();

    // single row: top-row lookups only, where only the longitude step enters the interpolation
    write_all(-500, 1000, 7, 3, 1, 2048, 0, 1);
    fill_phase(100);
    drain();

    if (mismatches == 0 && expected_lookups.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Test completed with failures");
    $finish;
  end

endmodule
